@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define EDN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every rising edge, reset included.
`define EDN_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/edn_pkg.sv @@
`timescale 1ns / 1ps

package edn_pkg;

    localparam int MAX_WORD_LEN = 16;
    localparam int LEN_W        = 5;
    localparam int CHAR_IDX_W   = 4;
    localparam int DIST_W       = 5;
    localparam int CHARS_W      = 64;
    localparam int HIT_CAP      = 8;
    localparam int HIT_SEL_W    = 3;
    localparam int COUNT_W      = 4;
    localparam int INDEX_BITS   = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HITS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ERRORS = 3'd4;

    // Operands of one matrix cell
    typedef struct packed {
        logic [DIST_W-1:0] diag;
        logic [DIST_W-1:0] up;
        logic [DIST_W-1:0] left;
        logic              mismatch;
    } cell_in_t;

    // Saturate a length to the longest word
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] n);
        clamp_len = (n > LEN_W'(MAX_WORD_LEN)) ? LEN_W'(MAX_WORD_LEN) : n;
    endfunction

    // Pick one byte of a 16-byte word
    function automatic logic [7:0] get_byte(input logic [CHARS_W-1:0] lo,
                                            input logic [CHARS_W-1:0] hi,
                                            input logic [CHAR_IDX_W-1:0] idx);
        logic [2*CHARS_W-1:0] both;
        both = {hi, lo};
        get_byte = both[idx*8 +: 8];
    endfunction

    // Error limit (3*len+9)/10 for a clamped length, as a small table
    function automatic logic [DIST_W-1:0] err_limit(input logic [LEN_W-1:0] q);
        logic [DIST_W-1:0] r;
        r = '0;
        case (q) inside
            5'd0:                r = 5'd0;
            [5'd1:5'd3]:         r = 5'd1;
            [5'd4:5'd6]:         r = 5'd2;
            [5'd7:5'd10]:        r = 5'd3;
            [5'd11:5'd13]:       r = 5'd4;
            default:             r = 5'd5;
        endcase
        err_limit = r;
    endfunction

endpackage

@@ rtl/edn_if.sv @@
`timescale 1ns / 1ps

interface edn_word_if;
    import edn_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHARS_W-1:0]   word_chars_low;
    logic [CHARS_W-1:0]   word_chars_high;
    logic [LEN_W-1:0]     word_len;
    logic                 last_word;

    modport source (output valid, word_chars_low, word_chars_high, word_len, last_word,
                    input ready);
    modport sink   (input valid, word_chars_low, word_chars_high, word_len, last_word,
                    output ready);
endinterface

interface edn_hit_if;
    import edn_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] hit_index;
    logic [DIST_W-1:0]     hit_distance;
    logic                  found;
    logic                  last_hit;

    modport source (output valid, hit_index, hit_distance, found, last_hit, input ready);
    modport sink   (input valid, hit_index, hit_distance, found, last_hit, output ready);
endinterface

@@ rtl/edit_distance_nearest_words_top.sv @@
`timescale 1ns / 1ps
// Each dictionary word walks a word_len x query_len matrix (lengths clamped to 16):
// the shared cell unit evaluates one edit-distance matrix cell per cycle.
// A word is taken only when the block is idle; the final word of a pass is followed by
// one result per cycle while the hit channel is ready (up to 8 results).
// rst_n clears control, pass state and configuration asynchronously; no clearing pass.
module edit_distance_nearest_words_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [edn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [edn_pkg::CFG_DATA_W-1:0]    cfg_data,
    edn_word_if.sink                          word,
    edn_hit_if.source                         hit
);
    import edn_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CELL   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_EMIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [CHARS_W-1:0] query_low_reg;
    logic [CHARS_W-1:0] query_high_reg;
    logic [LEN_W-1:0]   query_len_reg;
    logic [COUNT_W-1:0] max_hits_reg;
    logic [DIST_W-1:0]  max_errors_reg;

    // Latched word
    logic [CHARS_W-1:0] word_low_reg;
    logic [CHARS_W-1:0] word_high_reg;
    logic [LEN_W-1:0]   wlen_reg;
    logic               last_reg;

    // Matrix walk
    logic [DIST_W-1:0]  row_buf_reg [MAX_WORD_LEN];
    logic [LEN_W-1:0]   row_cnt_reg;
    logic [LEN_W-1:0]   col_cnt_reg;
    logic [DIST_W-1:0]  diag_reg;
    logic [DIST_W-1:0]  left_reg;

    // Pass state
    logic                  pass_active_reg;
    logic [DIST_W-1:0]     best_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [INDEX_BITS-1:0] word_cnt_reg;
    logic [INDEX_BITS-1:0] hit_list_reg [HIT_CAP];
    logic [HIT_SEL_W-1:0]  emit_reg;

    logic               in_xfer;
    logic               out_xfer;
    logic [LEN_W-1:0]   qlen;
    logic [LEN_W-1:0]   qlen_m1;
    logic [LEN_W-1:0]   in_wlen;
    logic [DIST_W-1:0]  limit;
    logic [COUNT_W-1:0] cap;
    logic [DIST_W-1:0]  word_dist;
    logic               take_better;
    logic               take_tie;
    logic [LEN_W-1:0]   row_m1;
    logic [LEN_W-1:0]   col_m1;
    logic [7:0]         word_char;
    logic [7:0]         query_char;
    cell_in_t           cell_in;
    logic [DIST_W-1:0]  cell_val;
    logic               col_done;
    logic               row_done;
    logic               emit_last;

    assign in_xfer  = word.valid && word.ready;
    assign out_xfer = hit.valid && hit.ready;
    assign word.ready = (state_reg == S_IDLE);

    assign qlen    = clamp_len(query_len_reg);
    assign qlen_m1 = qlen - LEN_W'(1);
    assign in_wlen = clamp_len(word.word_len);
    assign limit   = (err_limit(qlen) < max_errors_reg) ? err_limit(qlen) : max_errors_reg;
    assign cap     = (max_hits_reg > COUNT_W'(HIT_CAP)) ? COUNT_W'(HIT_CAP) : max_hits_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_low_reg  <= '0;
            query_high_reg <= '0;
            query_len_reg  <= '0;
            max_hits_reg   <= COUNT_W'(1);
            max_errors_reg <= DIST_W'(2);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_QUERY_LOW:  query_low_reg  <= cfg_data;
                REG_QUERY_HIGH: query_high_reg <= cfg_data;
                REG_QUERY_LEN:  query_len_reg  <= cfg_data[LEN_W-1:0];
                REG_MAX_HITS:   max_hits_reg   <= cfg_data[COUNT_W-1:0];
                REG_MAX_ERRORS: max_errors_reg <= cfg_data[DIST_W-1:0];
                default:        ;
            endcase
        end
    end

    // Select the characters for the current cell
    assign row_m1     = row_cnt_reg - LEN_W'(1);
    assign col_m1     = col_cnt_reg - LEN_W'(1);
    assign word_char  = get_byte(word_low_reg, word_high_reg, row_m1[CHAR_IDX_W-1:0]);
    assign query_char = get_byte(query_low_reg, query_high_reg, col_m1[CHAR_IDX_W-1:0]);

    always_comb
    begin
        cell_in.diag     = diag_reg;
        cell_in.up       = row_buf_reg[0];
        cell_in.left     = left_reg;
        cell_in.mismatch = (word_char != query_char);
    end

    edn_cell_unit u_cell (
        .cell_in  (cell_in),
        .cell_out (cell_val)
    );

    assign col_done = (col_cnt_reg == qlen);
    assign row_done = (row_cnt_reg == wlen_reg);

    // Hit decision
    assign word_dist = (qlen == '0) ? wlen_reg : row_buf_reg[qlen_m1[CHAR_IDX_W-1:0]];
    assign take_better = ((word_dist < best_reg) && (word_dist <= limit))
                      || ((word_dist == '0) && (count_reg == '0));
    assign take_tie    = (word_dist == best_reg) && (word_dist <= limit) && (count_reg < cap);

    assign emit_last = (count_reg == '0) || ({1'b0, emit_reg} + COUNT_W'(1) == count_reg);

    // Sequence the states
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if ((in_wlen == '0) || (qlen == '0))
                        state_next = S_DECIDE;
                    else
                        state_next = S_CELL;
                end
            end
            S_CELL:
            begin
                if (col_done && row_done)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_xfer && emit_last)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Latch the word and walk the matrix one cell at a time
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            word_low_reg  <= word.word_chars_low;
            word_high_reg <= word.word_chars_high;
            wlen_reg      <= in_wlen;
            last_reg      <= word.last_word;
            row_cnt_reg   <= LEN_W'(1);
            col_cnt_reg   <= LEN_W'(1);
            diag_reg      <= '0;
            left_reg      <= DIST_W'(1);
            for (int k = 0; k < MAX_WORD_LEN; k++)
            begin
                row_buf_reg[k] <= DIST_W'(k + 1);
            end
        end
        else if (state_reg == S_CELL)
        begin
            // Shift the row; the new cell lands at the row end
            for (int k = 0; k < MAX_WORD_LEN; k++)
            begin
                if (LEN_W'(k) == qlen_m1)
                    row_buf_reg[k] <= cell_val;
                else if (k < MAX_WORD_LEN - 1)
                    row_buf_reg[k] <= row_buf_reg[k + 1];
            end
            if (col_done)
            begin
                row_cnt_reg <= row_cnt_reg + LEN_W'(1);
                col_cnt_reg <= LEN_W'(1);
                diag_reg    <= row_cnt_reg;
                left_reg    <= row_cnt_reg + DIST_W'(1);
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + LEN_W'(1);
                diag_reg    <= row_buf_reg[0];
                left_reg    <= cell_val;
            end
        end
    end

    // Keep the pass state and the hit count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_active_reg <= 1'b0;
            best_reg        <= '0;
            count_reg       <= '0;
            word_cnt_reg    <= '0;
            emit_reg        <= '0;
        end
        else
        begin
            if (in_xfer && !pass_active_reg)
            begin
                pass_active_reg <= 1'b1;
                best_reg        <= qlen;
                count_reg       <= '0;
            end
            if (state_reg == S_DECIDE)
            begin
                if (take_better)
                begin
                    count_reg <= COUNT_W'(1);
                    best_reg  <= word_dist;
                end
                else if (take_tie)
                begin
                    count_reg <= count_reg + COUNT_W'(1);
                end
                word_cnt_reg <= last_reg ? '0 : word_cnt_reg + INDEX_BITS'(1);
                emit_reg     <= '0;
            end
            if ((state_reg == S_EMIT) && out_xfer)
            begin
                if (emit_last)
                begin
                    pass_active_reg <= 1'b0;
                    count_reg       <= '0;
                end
                else
                begin
                    emit_reg <= emit_reg + HIT_SEL_W'(1);
                end
            end
        end
    end

    // Record hit indexes
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DECIDE)
        begin
            if (take_better)
                hit_list_reg[0] <= word_cnt_reg;
            else if (take_tie)
                hit_list_reg[count_reg[HIT_SEL_W-1:0]] <= word_cnt_reg;
        end
    end

    // Present the results from the held pass state
    assign hit.valid        = (state_reg == S_EMIT);
    assign hit.found        = (count_reg != '0);
    assign hit.hit_index    = (count_reg == '0) ? '0 : hit_list_reg[emit_reg];
    assign hit.hit_distance = (count_reg == '0) ? '0 : best_reg;
    assign hit.last_hit     = emit_last;

endmodule

@@ rtl/edn_cell_unit.sv @@
`timescale 1ns / 1ps

module edn_cell_unit (
    input  edn_pkg::cell_in_t            cell_in,
    output logic [edn_pkg::DIST_W-1:0]   cell_out
);
    import edn_pkg::*;

    logic [DIST_W:0] sub_cost;
    logic [DIST_W:0] del_cost;
    logic [DIST_W:0] ins_cost;
    logic [DIST_W:0] min_sd;
    logic [DIST_W:0] min_all;

    // Take the cheapest of substitute, delete and insert
    always_comb
    begin
        sub_cost = {1'b0, cell_in.diag} + {{DIST_W{1'b0}}, cell_in.mismatch};
        del_cost = {1'b0, cell_in.up} + (DIST_W+1)'(1);
        ins_cost = {1'b0, cell_in.left} + (DIST_W+1)'(1);
        min_sd   = (sub_cost < del_cost) ? sub_cost : del_cost;
        min_all  = (min_sd < ins_cost) ? min_sd : ins_cost;
    end

    assign cell_out = min_all[DIST_W-1:0];

endmodule

@@ rtl/edn_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module edn_prop_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              word_valid,
    input logic                              word_ready,
    input logic                              hit_valid,
    input logic                              hit_ready,
    input logic [edn_pkg::INDEX_BITS-1:0]    hit_index,
    input logic [edn_pkg::DIST_W-1:0]        hit_distance,
    input logic                              hit_found,
    input logic                              hit_last
);

    // The block never takes a word while it shows a result
    `EDN_ASSERT(a_no_overlap, clk, rst_n, !(word_ready && hit_valid), "word taken during results")

    // A word transfer is never answered in the next cycle
    `EDN_ASSERT(a_no_early_result, clk, rst_n,
        (word_valid && word_ready) |=> !hit_valid, "result too early")

    // The not-found item is a single, final, all-zero item
    `EDN_ASSERT(a_not_found_shape, clk, rst_n,
        (hit_valid && !hit_found) |-> (hit_last && hit_index == '0 && hit_distance == '0),
        "bad not-found item")

    // After the final result the block is idle again
    `EDN_ASSERT(a_pass_end, clk, rst_n,
        (hit_valid && hit_ready && hit_last) |=> (word_ready && !hit_valid),
        "pass did not close")

    // A stalled result holds
    `EDN_ASSERT(a_hold, clk, rst_n,
        (hit_valid && !hit_ready) |=> (hit_valid && $stable(hit_index)
            && $stable(hit_distance) && $stable(hit_found) && $stable(hit_last)),
        "stalled result changed")

endmodule

bind edit_distance_nearest_words_top edn_prop_checker u_edn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .word_valid   (word.valid),
    .word_ready   (word.ready),
    .hit_valid    (hit.valid),
    .hit_ready    (hit.ready),
    .hit_index    (hit.hit_index),
    .hit_distance (hit.hit_distance),
    .hit_found    (hit.found),
    .hit_last     (hit.last_hit)
);

@@ bench/edn_checker.sv @@
`timescale 1ns / 1ps

module edn_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [edn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [edn_pkg::CFG_DATA_W-1:0] cfg_data,
    edn_word_if                            word,
    edn_hit_if                             hit,
    output int                             fail_count,
    output int                             outstanding
);
    import edn_pkg::*;

    typedef logic [2*CHARS_W-1:0] text_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic [DIST_W-1:0]     dist_val;
        logic                  found;
        logic                  last;
    } hit_rec_t;

    // Shadow of the configuration registers
    text_t              query_text;
    logic [LEN_W-1:0]   query_len_cfg;
    logic [COUNT_W-1:0] hit_cap_cfg;
    logic [DIST_W-1:0]  error_cap_cfg;

    // Search state of the current dictionary pass
    int                    best_dist;
    int                    kept_count;
    logic [INDEX_BITS-1:0] kept_index [HIT_CAP];
    logic [INDEX_BITS-1:0] word_pos;
    bit                    pass_open;

    hit_rec_t expected_hits [$];

    // Levenshtein distance, one matrix row per word character
    function automatic int edit_cost(input text_t w, input int wl, input text_t q, input int ql);
        int above [MAX_WORD_LEN+1];
        int row [MAX_WORD_LEN+1];
        int sub;
        int low;
        for (int j = 0; j <= ql; j++)
            above[j] = j;
        for (int i = 1; i <= wl; i++)
        begin
            row[0] = i;
            for (int j = 1; j <= ql; j++)
            begin
                sub = above[j-1] + ((w[(i-1)*8 +: 8] == q[(j-1)*8 +: 8]) ? 0 : 1);
                low = (above[j] + 1 < sub) ? above[j] + 1 : sub;
                row[j] = (row[j-1] + 1 < low) ? row[j-1] + 1 : low;
            end
            above = row;
        end
        return above[ql];
    endfunction

    // Score one dictionary word and queue the pass results on the final word
    task automatic score_word(input text_t w, input logic [LEN_W-1:0] len_raw, input logic last);
        int       qlen;
        int       wlen;
        int       limit;
        int       cap;
        int       word_dist;
        hit_rec_t rec;
        qlen  = (query_len_cfg > MAX_WORD_LEN) ? MAX_WORD_LEN : int'(query_len_cfg);
        wlen  = (len_raw > MAX_WORD_LEN) ? MAX_WORD_LEN : int'(len_raw);
        limit = (3 * qlen + 9) / 10;
        if (int'(error_cap_cfg) < limit)
            limit = int'(error_cap_cfg);
        cap = (hit_cap_cfg > HIT_CAP) ? HIT_CAP : int'(hit_cap_cfg);

        if (!pass_open)
        begin
            best_dist  = qlen;
            kept_count = 0;
            pass_open  = 1'b1;
        end

        word_dist = edit_cost(w, wlen, query_text, qlen);
        // a strictly closer word, or the first exact one, restarts the list
        if ((word_dist < best_dist && word_dist <= limit) || (word_dist == 0 && kept_count == 0))
        begin
            kept_index[0] = word_pos;
            kept_count    = 1;
            best_dist     = word_dist;
        end
        else if (word_dist == best_dist && word_dist <= limit && kept_count < cap)
        begin
            kept_index[kept_count] = word_pos;
            kept_count++;
        end
        word_pos++;

        if (last)
        begin
            if (kept_count == 0)
            begin
                rec = '{index: '0, dist_val: '0, found: 1'b0, last: 1'b1};
                expected_hits = {expected_hits, rec};
            end
            else
                for (int k = 0; k < kept_count; k++)
                begin
                    rec = '{index: kept_index[k], dist_val: DIST_W'(best_dist),
                            found: 1'b1, last: (k == kept_count - 1)};
                    expected_hits = {expected_hits, rec};
                end
            pass_open  = 1'b0;
            kept_count = 0;
            word_pos   = '0;
        end
    endtask

    function automatic void check_field(input string name, input int unsigned exp,
                                        input int unsigned act);
        if (exp != act)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
            fail_count++;
        end
    endfunction

    // Compare one hit transfer with the oldest expectation
    task automatic match_hit();
        hit_rec_t due;
        if (expected_hits.size() == 0)
        begin
            $error("unexpected hit transfer: hit_index %0d, hit_distance %0d",
                   hit.hit_index, hit.hit_distance);
            fail_count++;
        end
        else
        begin
            due = expected_hits.pop_front();
            check_field("hit_index", 32'(due.index), 32'(hit.hit_index));
            check_field("hit_distance", 32'(due.dist_val), 32'(hit.hit_distance));
            check_field("found", 32'(due.found), 32'(hit.found));
            check_field("last_hit", 32'(due.last), 32'(hit.last_hit));
        end
    endtask

    // Watch configuration writes and both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_text    = '0;
            query_len_cfg = '0;
            hit_cap_cfg   = COUNT_W'(1);
            error_cap_cfg = DIST_W'(2);
            best_dist     = 0;
            kept_count    = 0;
            word_pos      = '0;
            pass_open     = 1'b0;
            fail_count    = 0;
            expected_hits.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_QUERY_LOW:  query_text[CHARS_W-1:0] = cfg_data;
                    REG_QUERY_HIGH: query_text[2*CHARS_W-1:CHARS_W] = cfg_data;
                    REG_QUERY_LEN:  query_len_cfg = cfg_data[LEN_W-1:0];
                    REG_MAX_HITS:   hit_cap_cfg = cfg_data[COUNT_W-1:0];
                    REG_MAX_ERRORS: error_cap_cfg = cfg_data[DIST_W-1:0];
                    default:        ;
                endcase
            end
            if (hit.valid && hit.ready)
                match_hit();
            if (word.valid && word.ready)
                score_word({word.word_chars_high, word.word_chars_low}, word.word_len,
                           word.last_word);
        end
        outstanding = expected_hits.size();
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import edn_pkg::*;

    typedef logic [2*CHARS_W-1:0] text_t;
    typedef enum int {EDIT_SUB, EDIT_INS, EDIT_DEL} edit_kind_t;

    localparam int     SETTLE_CYCLES = 300;
    localparam int     LONG_STALL    = 2000;
    localparam int     PHASE_WORDS   = 70;
    localparam longint RUN_LIMIT_NS  = 5_000_000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    stall_requests = 0;
    int    stall_served = 0;
    int    stall_left = 0;
    int    fail_count;
    int    outstanding;
    text_t cur_query;
    int    cur_qlen;

    edn_word_if word_ch();
    edn_hit_if  hit_ch();

    edit_distance_nearest_words_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .word      (word_ch),
        .hit       (hit_ch)
    );

    edn_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .word        (word_ch),
        .hit         (hit_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drive hit ready: random idling, or a long hold when one is requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            hit_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (stall_requests != stall_served)
        begin
            hit_ch.ready <= 1'b0;
            stall_left   <= LONG_STALL;
            stall_served <= stall_served + 1;
        end
        else
            hit_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [7:0] rand_letter();
        return 8'h61 + 8'($urandom_range(3));
    endfunction

    function automatic text_t pack_text(input string s);
        text_t v;
        v = '0;
        for (int i = 0; i < s.len() && i < MAX_WORD_LEN; i++)
            v[i*8 +: 8] = s[i];
        return v;
    endfunction

    // Derive a dictionary word a few edits away from the current query
    task automatic near_word(output text_t w, output logic [LEN_W-1:0] wl);
        logic [7:0] bytes_q [$];
        edit_kind_t kind;
        for (int i = 0; i < cur_qlen; i++)
            bytes_q = {bytes_q, cur_query[i*8 +: 8]};
        repeat ($urandom_range(3))
        begin
            kind = edit_kind_t'($urandom_range(2));
            case (kind)
                EDIT_SUB:
                    if (bytes_q.size() > 0)
                        bytes_q[$urandom_range(bytes_q.size() - 1)] = rand_letter();
                EDIT_INS:
                    if (bytes_q.size() < MAX_WORD_LEN)
                        bytes_q.insert($urandom_range(bytes_q.size()), rand_letter());
                EDIT_DEL:
                    if (bytes_q.size() > 0)
                        bytes_q.delete($urandom_range(bytes_q.size() - 1));
                default: ;
            endcase
        end
        w = '0;
        foreach (bytes_q[i])
            w[i*8 +: 8] = bytes_q[i];
        wl = LEN_W'(bytes_q.size());
    endtask

    // Write all five registers back to back
    task automatic set_config(input text_t query, input logic [LEN_W-1:0] qlen,
                              input logic [COUNT_W-1:0] hits, input logic [DIST_W-1:0] errs);
        logic [CFG_IDX_W-1:0]  regs [5];
        logic [CFG_DATA_W-1:0] vals [5];
        regs = '{REG_QUERY_LOW, REG_QUERY_HIGH, REG_QUERY_LEN, REG_MAX_HITS, REG_MAX_ERRORS};
        vals = '{query[CHARS_W-1:0], query[2*CHARS_W-1:CHARS_W], CFG_DATA_W'(qlen),
                 CFG_DATA_W'(hits), CFG_DATA_W'(errs)};
        cur_query = query;
        cur_qlen  = (qlen > MAX_WORD_LEN) ? MAX_WORD_LEN : int'(qlen);
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Offer one word and hold it until the transfer
    task automatic send_word(input text_t w, input logic [LEN_W-1:0] wl, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            word_ch.valid <= 1'b0;
            @(posedge clk);
        end
        word_ch.valid           <= 1'b1;
        word_ch.word_chars_low  <= w[CHARS_W-1:0];
        word_ch.word_chars_high <= w[2*CHARS_W-1:CHARS_W];
        word_ch.word_len        <= wl;
        word_ch.last_word       <= last;
        @(posedge clk);
        while (!word_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid, wait for every pending hit, then let the block drain
    task automatic settle();
        word_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random passes under a fresh configuration each round
    task automatic run_random(input int n_words);
        int               sent;
        int               pass_words;
        int               pick;
        text_t            q;
        text_t            w;
        logic [LEN_W-1:0] ql;
        logic [LEN_W-1:0] wl;
        sent = 0;
        while (sent < n_words)
        begin
            settle();
            pick = $urandom_range(9);
            if (pick == 0)
                ql = '0;
            else if (pick == 1)
                ql = LEN_W'($urandom_range(16, 31));
            else
                ql = LEN_W'($urandom_range(1, 12));
            for (int i = 0; i < MAX_WORD_LEN; i++)
                q[i*8 +: 8] = rand_letter();
            if ($urandom_range(6) == 0)
                q = {$urandom, $urandom, $urandom, $urandom};
            set_config(q, ql, COUNT_W'($urandom_range(15)),
                       ($urandom_range(3) == 0) ? DIST_W'($urandom_range(31))
                                                : DIST_W'($urandom_range(4)));
            repeat ($urandom_range(1, 4))
            begin
                pass_words = $urandom_range(1, 8);
                for (int k = 0; k < pass_words; k++)
                begin
                    pick = $urandom_range(9);
                    if (pick < 6)
                        near_word(w, wl);
                    else if (pick < 8)
                    begin
                        for (int i = 0; i < MAX_WORD_LEN; i++)
                            w[i*8 +: 8] = rand_letter();
                        wl = LEN_W'($urandom_range(MAX_WORD_LEN));
                    end
                    else
                    begin
                        w  = {$urandom, $urandom, $urandom, $urandom};
                        wl = LEN_W'($urandom_range(31));
                    end
                    send_word(w, wl, k == pass_words - 1);
                    sent++;
                end
            end
        end
    endtask

    // Abort a hung run
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("edit_distance_nearest_words_top verification failed");
        $finish;
    end

    initial
    begin
        text_t            ones;
        text_t            w;
        logic [LEN_W-1:0] wl;
        ones = '1;
        cfg_we                  <= 1'b0;
        cfg_index               <= REG_QUERY_LOW;
        cfg_data                <= '0;
        word_ch.valid           <= 1'b0;
        word_ch.word_chars_low  <= '0;
        word_ch.word_chars_high <= '0;
        word_ch.word_len        <= '0;
        word_ch.last_word       <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 8;
        recv_idle_pct = 53;

        // empty word against the empty reset query is an exact match
        send_word('0, '0, 1'b1);
        settle();

        // ties append up to the hit cap; then an exact match; then no hit at all
        set_config(pack_text("kitten"), 5'd6, 4'd3, 5'd16);
        send_word(pack_text("sitten"), 5'd6, 1'b0);
        send_word(pack_text("kitton"), 5'd6, 1'b0);
        send_word(pack_text("bitter"), 5'd6, 1'b0);
        send_word(pack_text("kittens"), 5'd7, 1'b1);
        send_word(pack_text("kitten"), 5'd6, 1'b1);
        send_word(pack_text("dog"), 5'd3, 1'b1);
        settle();

        // zero hit cap still keeps a strictly better word
        set_config(pack_text("kitten"), 5'd6, 4'd0, 5'd16);
        send_word(pack_text("sitten"), 5'd6, 1'b0);
        send_word(pack_text("mitten"), 5'd6, 1'b1);
        settle();

        // oversize lengths clamp; saturated cap fills all eight slots
        set_config(ones, 5'd31, 4'd15, 5'd31);
        for (int k = 0; k < HIT_CAP; k++)
            send_word(ones, k[0] ? 5'd16 : 5'd31, 1'b0);
        send_word('0, 5'd16, 1'b1);
        settle();

        // change the query between words of one pass
        set_config(pack_text("abc"), 5'd3, 4'd1, 5'd2);
        send_word(pack_text("abd"), 5'd3, 1'b0);
        settle();
        set_config(pack_text("abd"), 5'd3, 4'd1, 5'd2);
        send_word(pack_text("xyz"), 5'd3, 1'b1);

        run_random(PHASE_WORDS);

        send_idle_pct = 53;
        recv_idle_pct = 8;
        run_random(PHASE_WORDS);

        // hold hit ready low while full passes keep coming
        settle();
        stall_requests = stall_requests + 1;
        repeat (12)
        begin
            near_word(w, wl);
            send_word(w, wl, 1'b1);
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_WORDS);
        settle();

        if (fail_count == 0 && outstanding == 0)
            $display("edit_distance_nearest_words_top verification clean");
        else
            $display("edit_distance_nearest_words_top verification failed");
        $finish;
    end

endmodule
